/* hdl/pmm_pkg.sv */
// shared types, constants and fixed-point helpers for the polynomial model cost block
package pmm_pkg;

	// data widths
	localparam int unsigned DATA_W = 32;
	localparam int unsigned SQ_W   = 48;
	localparam int unsigned SUM_W  = 64;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_0 = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_1 = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_3 = 2'd3;

	// decoupling queue between front and back
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

	// word passed from front to back
	typedef struct packed {
		logic signed [DATA_W-1:0] prediction;
		logic [SQ_W-1:0]          sq_error;
		logic                     last_sample;
	} pmm_item_t;

	// q16.16 multiply, floor rounding, saturated to signed 32 bits
	function automatic logic signed [DATA_W-1:0] qmul(
		input logic signed [DATA_W-1:0] a,
		input logic signed [DATA_W-1:0] b
	);
		logic signed [2*DATA_W-1:0] p;
		logic signed [DATA_W-1:0]   r;
		begin
			p = a * b;
			if (p[63:47] == {17{1'b0}} || p[63:47] == {17{1'b1}}) begin
				r = p[47:16];
			end else if (p[63]) begin
				r = {1'b1, {(DATA_W-1){1'b0}}};
			end else begin
				r = {1'b0, {(DATA_W-1){1'b1}}};
			end
			return r;
		end
	endfunction

endpackage

/* hdl/pmm_front.sv */
// front: coefficient registers and the prediction / squared error pipeline
module pmm_front import pmm_pkg::*; #(
	parameter int unsigned TERMS = 4
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_write,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [DATA_W-1:0]        cfg_data,
	input  logic                     push,
	output logic                     full,
	input  logic signed [DATA_W-1:0] measurement,
	input  logic signed [DATA_W-1:0] observation,
	input  logic                     last_sample,
	output logic                     q_push,
	input  logic                     q_full,
	output pmm_item_t                q_word
);

	logic signed [DATA_W-1:0] coef_0_q, coef_1_q, coef_2_q, coef_3_q;
	logic adv;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic signed [DATA_W-1:0] x_s1, x2_s1, x3_s2;
	logic signed [DATA_W-1:0] t1_s1, t1_s2, t1_s3, t2_s2, t2_s3, t3_s3;
	logic signed [DATA_W-1:0] obs_s1, obs_s2, obs_s3, obs_s4;
	logic signed [DATA_W-1:0] pred_s4, pred_s5, pred_s6;
	logic [DATA_W-1:0]        mag_s5;
	logic [SQ_W-1:0]          sq_s6;
	logic last_s1, last_s2, last_s3, last_s4, last_s5, last_s6;

	logic signed [DATA_W+1:0] term_sum;
	logic signed [DATA_W-1:0] pred_sat;
	logic signed [DATA_W:0]   diff;
	logic [2*DATA_W-1:0]      mag_prod;

	// coefficient registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_0_q <= '0;
			coef_1_q <= '0;
			coef_2_q <= '0;
			coef_3_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_COEF_0: coef_0_q <= cfg_data;
				REG_COEF_1: coef_1_q <= cfg_data;
				REG_COEF_2: coef_2_q <= cfg_data;
				REG_COEF_3: coef_3_q <= cfg_data;
				default:    coef_0_q <= coef_0_q;
			endcase
		end
	end

	// whole pipeline moves unless the tail word is stuck on a full queue
	assign adv    = !v_s6 || !q_full;
	assign full   = !adv;
	assign q_push = v_s6 && !q_full;

	// pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s1 <= push;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// sum of enabled terms, saturated
	always_comb begin
		term_sum = '0;
		term_sum = term_sum + (DATA_W+2)'(coef_0_q);
		if (TERMS >= 2) term_sum = term_sum + (DATA_W+2)'(t1_s3);
		if (TERMS >= 3) term_sum = term_sum + (DATA_W+2)'(t2_s3);
		if (TERMS >= 4) term_sum = term_sum + (DATA_W+2)'(t3_s3);
		if (term_sum > (DATA_W+2)'(34'sh0_7fff_ffff)) begin
			pred_sat = {1'b0, {(DATA_W-1){1'b1}}};
		end else if (term_sum < -(DATA_W+2)'(34'sh0_8000_0000)) begin
			pred_sat = {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			pred_sat = term_sum[DATA_W-1:0];
		end
	end

	// error magnitude and its square
	assign diff     = (DATA_W+1)'(pred_s4) - (DATA_W+1)'(obs_s4);
	assign mag_prod = (2*DATA_W)'(mag_s5) * (2*DATA_W)'(mag_s5);

	// pipeline payload
	always_ff @(posedge clk) begin
		if (adv) begin
			// stage 1: x^2 and linear term
			x_s1    <= measurement;
			x2_s1   <= qmul(measurement, measurement);
			t1_s1   <= qmul(coef_1_q, measurement);
			obs_s1  <= observation;
			last_s1 <= last_sample;
			// stage 2: x^3 and squared term
			x3_s2   <= qmul(x2_s1, x_s1);
			t2_s2   <= qmul(coef_2_q, x2_s1);
			t1_s2   <= t1_s1;
			obs_s2  <= obs_s1;
			last_s2 <= last_s1;
			// stage 3: cubed term
			t3_s3   <= qmul(coef_3_q, x3_s2);
			t1_s3   <= t1_s2;
			t2_s3   <= t2_s2;
			obs_s3  <= obs_s2;
			last_s3 <= last_s2;
			// stage 4: prediction
			pred_s4 <= pred_sat;
			obs_s4  <= obs_s3;
			last_s4 <= last_s3;
			// stage 5: error magnitude
			mag_s5  <= diff[DATA_W] ? DATA_W'(-diff) : diff[DATA_W-1:0];
			pred_s5 <= pred_s4;
			last_s5 <= last_s4;
			// stage 6: squared error in unsigned q32.16
			sq_s6   <= mag_prod[2*DATA_W-1:16];
			pred_s6 <= pred_s5;
			last_s6 <= last_s5;
		end
	end

	// word handed to the queue
	assign q_word.prediction  = pred_s6;
	assign q_word.sq_error    = sq_s6;
	assign q_word.last_sample = last_s6;

endmodule

/* hdl/pmm_queue.sv */
// short word queue between the front pipeline and the back accumulator
module pmm_queue import pmm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      wr_en,
	input  pmm_item_t wr_word,
	output logic      q_full,
	input  logic      rd_en,
	output pmm_item_t rd_word,
	output logic      q_empty
);

	pmm_item_t                store_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QUEUE_PTR_W:0]     fill_q;

	assign q_full  = (fill_q == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
	assign q_empty = (fill_q == '0);
	assign rd_word = store_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_q[wr_ptr_q] <= wr_word;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (wr_en) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (rd_en) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (wr_en && !rd_en) begin
				fill_q <= fill_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

/* hdl/pmm_back.sv */
// back: error accumulator, sample counter, batch divider and result register
module pmm_back import pmm_pkg::*; #(
	parameter int unsigned MAX_SAMPLES = 65536
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  pmm_item_t                q_word,
	input  logic                     q_empty,
	output logic                     q_pop,
	input  logic                     pop,
	output logic                     empty,
	output logic signed [DATA_W-1:0] prediction,
	output logic [DATA_W-1:0]        mean_error,
	output logic                     error_valid
);

	localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1);
	localparam int unsigned DEN_W = CNT_W + 1;
	localparam int unsigned STEP_W = $clog2(SUM_W);

	localparam logic [1:0] ST_RUN = 2'd0;
	localparam logic [1:0] ST_DIV = 2'd1;
	localparam logic [1:0] ST_FIN = 2'd2;

	logic [1:0]               state_q;
	logic [SUM_W-1:0]         sum_q, num_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [DEN_W-1:0]         den_q, rem_q;
	logic [STEP_W-1:0]        step_q;
	logic signed [DATA_W-1:0] pred_hold_q;
	logic                     out_valid_q;
	logic signed [DATA_W-1:0] pred_q;
	logic [DATA_W-1:0]        mean_q;
	logic                     err_valid_q;

	logic                     out_free;
	logic [SUM_W:0]           sum_wide;
	logic [SUM_W-1:0]         sum_next;
	logic [CNT_W-1:0]         cnt_next;
	logic [DEN_W:0]           rem_shift;
	logic                     rem_ge;

	assign out_free = !out_valid_q || pop;
	assign q_pop    = (state_q == ST_RUN) && !q_empty && out_free;

	// saturating accumulate and count
	assign sum_wide = {1'b0, sum_q} + (SUM_W+1)'(q_word.sq_error);
	assign sum_next = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
	assign cnt_next = (cnt_q < CNT_W'(MAX_SAMPLES)) ? cnt_q + 1'b1 : cnt_q;

	// one restoring division step
	assign rem_shift = {rem_q, num_q[SUM_W-1]};
	assign rem_ge    = rem_shift >= (DEN_W+1)'(den_q);

	// result register occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((q_pop && !q_word.last_sample) || (state_q == ST_FIN && out_free)) begin
			out_valid_q <= 1'b1;
		end else if (pop && !empty) begin
			out_valid_q <= 1'b0;
		end
	end

	// control, accumulator and divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			sum_q       <= '0;
			cnt_q       <= '0;
			step_q      <= '0;
		end else begin
			case (state_q)
				ST_RUN: begin
					if (q_pop) begin
						if (q_word.last_sample) begin
							sum_q   <= '0;
							cnt_q   <= '0;
							step_q  <= '0;
							state_q <= ST_DIV;
						end else begin
							sum_q       <= sum_next;
							cnt_q       <= cnt_next;
						end
					end
				end
				ST_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(SUM_W - 1)) state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						state_q     <= ST_RUN;
					end
				end
				default: state_q <= ST_RUN;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_RUN: begin
				if (q_pop) begin
					if (q_word.last_sample) begin
						num_q       <= sum_next;
						den_q       <= {cnt_next, 1'b0};
						rem_q       <= '0;
						pred_hold_q <= q_word.prediction;
					end else begin
						pred_q      <= q_word.prediction;
						mean_q      <= '0;
						err_valid_q <= 1'b0;
					end
				end
			end
			ST_DIV: begin
				// quotient bits shift in where dividend bits shift out
				if (rem_ge) begin
					rem_q <= DEN_W'(rem_shift - (DEN_W+1)'(den_q));
				end else begin
					rem_q <= rem_shift[DEN_W-1:0];
				end
				num_q <= {num_q[SUM_W-2:0], rem_ge};
			end
			ST_FIN: begin
				if (out_free) begin
					pred_q      <= pred_hold_q;
					mean_q      <= (num_q[SUM_W-1:DATA_W] != '0) ? {DATA_W{1'b1}}
					                                             : num_q[DATA_W-1:0];
					err_valid_q <= 1'b1;
				end
			end
			default: pred_q <= pred_q;
		endcase
	end

	assign empty       = !out_valid_q;
	assign prediction  = pred_q;
	assign mean_error  = mean_q;
	assign error_valid = err_valid_q;

endmodule

/* hdl/polynomial_model_mse.sv */
// top level of the polynomial model mean squared error block
//
// Usage: write coefficient_0..3 through cfg_write / cfg_index / cfg_data while idle.
// Samples enter through a queue-style port: a word is taken when push is high and
// full is low. Results leave the same way: the oldest result sits on prediction,
// mean_error and error_valid while empty is low and is taken when pop is high.
// Every sample gives one result word; on the sample marked last_sample the word
// also carries the batch error and error_valid, and the batch sum and count clear.
// An ordinary sample's result passes the front pipeline, the queue and the result
// register; a last sample's result also waits for the bit-serial batch division.
// Throughput: one sample per cycle while full is low, set by the six-stage front
// pipeline and the accumulator; while a last sample is divided the back end takes
// no queue words, and the four-word queue absorbs the front end meanwhile.
// When the receiver stalls, the result register holds, the queue fills, and then
// full rises and stays high until pop frees room.
// Reset clears coefficients and the batch sum and count, and empties the queue and the result register.
module polynomial_model_mse import pmm_pkg::*; #(
	parameter int unsigned TERMS       = 4,
	parameter int unsigned MAX_SAMPLES = 65536
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_write,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [DATA_W-1:0]        cfg_data,
	input  logic                     push,
	output logic                     full,
	input  logic signed [DATA_W-1:0] measurement,
	input  logic signed [DATA_W-1:0] observation,
	input  logic                     last_sample,
	input  logic                     pop,
	output logic                     empty,
	output logic signed [DATA_W-1:0] prediction,
	output logic [DATA_W-1:0]        mean_error,
	output logic                     error_valid
);

	logic      f_push, f_full, b_pop, b_empty;
	pmm_item_t f_word, b_word;

	// prediction and squared error pipeline
	pmm_front #(.TERMS(TERMS)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.push        (push),
		.full        (full),
		.measurement (measurement),
		.observation (observation),
		.last_sample (last_sample),
		.q_push      (f_push),
		.q_full      (f_full),
		.q_word      (f_word)
	);

	// decoupling queue
	pmm_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (f_push),
		.wr_word (f_word),
		.q_full  (f_full),
		.rd_en   (b_pop),
		.rd_word (b_word),
		.q_empty (b_empty)
	);

	// accumulator, divider and result register
	pmm_back #(.MAX_SAMPLES(MAX_SAMPLES)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_word      (b_word),
		.q_empty     (b_empty),
		.q_pop       (b_pop),
		.pop         (pop),
		.empty       (empty),
		.prediction  (prediction),
		.mean_error  (mean_error),
		.error_valid (error_valid)
	);

endmodule

/* bench/polynomial_model_mse_tb.sv */
// self-checking bench for the polynomial model mean squared error block
`timescale 1ns / 100ps

module polynomial_model_mse_tb import pmm_pkg::*;;

	localparam int unsigned TERMS_USED    = 4;
	localparam int unsigned MAX_COUNT     = 65536;
	localparam int unsigned RANDOM_PHASES = 6;
	localparam int unsigned PHASE_ITEMS   = 250;
	localparam int unsigned HOLD_CYCLES   = 300;
	localparam int unsigned SETTLE_CYCLES = 4;
	localparam int unsigned TAIL_CYCLES   = 100;
	localparam int unsigned CYCLE_LIMIT   = 1000000;
	localparam int unsigned REPORT_LIMIT  = 10;

	localparam logic signed [DATA_W-1:0] Q_MAX       = 32'sh7FFFFFFF;
	localparam logic signed [DATA_W-1:0] Q_MIN       = 32'sh80000000;
	localparam logic signed [DATA_W-1:0] Q_ONE_FX    = 32'sh00010000;
	localparam logic signed [DATA_W-1:0] Q_MINUS_ONE = 32'shFFFF0000;

	typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;
	typedef enum logic [1:0] {STYLE_SMALL, STYLE_FULL, STYLE_CORNER, STYLE_SPARSE} coef_style_t;

	typedef struct {
		logic signed [DATA_W-1:0] prediction;
		logic [DATA_W-1:0]        mean_error;
		logic                     error_valid;
	} result_word_t;

	typedef struct {
		row_kind_t                kind;
		logic [CFG_IDX_W-1:0]     reg_index;
		logic [DATA_W-1:0]        value;
		logic signed [DATA_W-1:0] meas;
		logic signed [DATA_W-1:0] obs;
		logic                     last;
		logic                     typed;
		result_word_t             want;
	} stimulus_row_t;

	// block ports
	logic                     clk;
	logic                     arst_n;
	logic                     cfg_write;
	logic [CFG_IDX_W-1:0]     cfg_index;
	logic [DATA_W-1:0]        cfg_data;
	logic                     push;
	logic                     full;
	logic signed [DATA_W-1:0] measurement;
	logic signed [DATA_W-1:0] observation;
	logic                     last_sample;
	logic                     pop;
	logic                     empty;
	logic signed [DATA_W-1:0] prediction;
	logic [DATA_W-1:0]        mean_error;
	logic                     error_valid;

	// typed expectation travelling with the offered word
	logic         typed_expect;
	result_word_t typed_word;

	// predictor state
	logic signed [DATA_W-1:0] coef_model [TERMS_USED];
	logic [SUM_W-1:0]         error_sum;
	int unsigned              sample_total;
	int unsigned              batch_length;
	int unsigned              longest_batch;
	result_word_t             pending_results [$];

	// run bookkeeping
	logic        fast_mode;
	logic        hold_request;
	int unsigned mismatches;
	int unsigned words_checked;
	int unsigned batches_closed;
	int unsigned samples_taken;
	int unsigned writes_seen;
	int unsigned input_stalls;
	int unsigned cycle_count;

	polynomial_model_mse dut (
		.clk,
		.arst_n,
		.cfg_write,
		.cfg_index,
		.cfg_data,
		.push,
		.full,
		.measurement,
		.observation,
		.last_sample,
		.pop,
		.empty,
		.prediction,
		.mean_error,
		.error_valid
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// run limit
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words outstanding", cycle_count,
				pending_results.size());
			$display("simulation failed");
			$finish;
		end
	end

	// saturate to signed 32 bits
	function automatic logic signed [DATA_W-1:0] clamp32(input longint v);
		if (v > longint'(Q_MAX))
			return Q_MAX;
		if (v < longint'(Q_MIN))
			return Q_MIN;
		return v[DATA_W-1:0];
	endfunction

	// q16.16 product, floor rounding, saturated
	function automatic logic signed [DATA_W-1:0] fix_mul(
		input logic signed [DATA_W-1:0] a,
		input logic signed [DATA_W-1:0] b
	);
		longint p;
		p = longint'(a) * longint'(b);
		return clamp32(p >>> 16);
	endfunction

	// polynomial value, squared error accumulation and batch mean for one sample
	function automatic result_word_t score_sample(
		input logic signed [DATA_W-1:0] x,
		input logic signed [DATA_W-1:0] obs,
		input logic                     last
	);
		result_word_t             r;
		logic signed [DATA_W-1:0] power;
		longint                   acc;
		longint                   diff;
		logic [63:0]              mag;
		logic [63:0]              sq;
		logic [63:0]              divisor;
		logic [63:0]              quotient;
		logic [64:0]              widened;
		int                       k;
		acc = 0;
		power = Q_ONE_FX;
		for (k = 0; k < TERMS_USED; k++) begin
			acc += longint'(fix_mul(coef_model[k], power));
			power = (k == 0) ? x : fix_mul(power, x);
		end
		r.prediction = clamp32(acc);

		// exact difference, squared back to unsigned q32.16
		diff = longint'(r.prediction) - longint'(obs);
		mag = (diff < 0) ? -diff : diff;
		sq = (mag * mag) >> 16;
		widened = {1'b0, error_sum} + {1'b0, sq};
		error_sum = widened[SUM_W] ? {SUM_W{1'b1}} : widened[SUM_W-1:0];
		if (sample_total < MAX_COUNT)
			sample_total++;
		batch_length++;

		r.error_valid = last;
		r.mean_error = '0;
		if (last) begin
			divisor = 64'(sample_total) << 1;
			quotient = error_sum / divisor;
			r.mean_error = (quotient > 64'hFFFFFFFF) ? {DATA_W{1'b1}} : quotient[DATA_W-1:0];
			if (batch_length > longest_batch)
				longest_batch = batch_length;
			error_sum = '0;
			sample_total = 0;
			batch_length = 0;
		end
		return r;
	endfunction

	// watch both handshakes and the register port at every rising edge
	initial begin
		foreach (coef_model[k])
			coef_model[k] = '0;
		error_sum = '0;
		sample_total = 0;
		batch_length = 0;
		longest_batch = 0;
		mismatches = 0;
		words_checked = 0;
		batches_closed = 0;
		samples_taken = 0;
		writes_seen = 0;
		input_stalls = 0;
	end

	always @(posedge clk) begin
		result_word_t want;
		result_word_t scored;
		if (arst_n) begin
			// result word leaving the block
			if (pop && !empty) begin
				words_checked++;
				if (error_valid)
					batches_closed++;
				if (pending_results.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("unexpected word: prediction %h mean %h valid %b",
							prediction, mean_error, error_valid);
				end else begin
					want = pending_results.pop_front();
					if (prediction !== want.prediction || mean_error !== want.mean_error ||
							error_valid !== want.error_valid) begin
						mismatches++;
						if (mismatches <= REPORT_LIMIT)
							$display({"word %0d: expected prediction %h mean %h valid %b, ",
								"got %h %h %b"}, words_checked, want.prediction,
								want.mean_error, want.error_valid, prediction, mean_error,
								error_valid);
					end
				end
			end

			// coefficient write
			if (cfg_write) begin
				coef_model[cfg_index] = cfg_data;
				writes_seen++;
			end

			// sample word entering the block
			if (push && full)
				input_stalls++;
			if (push && !full) begin
				samples_taken++;
				scored = score_sample(measurement, observation, last_sample);
				pending_results.push_back(typed_expect ? typed_word : scored);
			end
		end
	end

	// gap length: mostly none or short, now and then long
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(3, 1);
		if (r < 98)
			return $urandom_range(12, 4);
		return $urandom_range(60, 20);
	endfunction

	function automatic logic signed [DATA_W-1:0] corner_value();
		case ($urandom_range(5))
			0: return Q_MIN;
			1: return Q_MAX;
			2: return '0;
			3: return Q_ONE_FX;
			4: return Q_MINUS_ONE;
			default: return 32'sh00000001;
		endcase
	endfunction

	// sample values: mostly modest so the polynomial stays in range
	function automatic logic signed [DATA_W-1:0] random_fixed();
		logic signed [DATA_W-1:0] v;
		case ($urandom_range(9))
			0, 1, 2, 3: v = $signed($urandom) >>> 13;
			4, 5: v = $signed($urandom) >>> 6;
			6, 7: v = $urandom;
			8: v = corner_value();
			default: v = $signed(32'd1 << $urandom_range(31));
		endcase
		return v;
	endfunction

	function automatic logic [DATA_W-1:0] pick_coefficient(input coef_style_t style);
		case (style)
			STYLE_SMALL: return $signed($urandom) >>> 14;
			STYLE_FULL: return $urandom;
			STYLE_CORNER: return corner_value();
			default: return $urandom_range(1) ? '0 : $signed($urandom) >>> 10;
		endcase
	endfunction

	function automatic int unsigned pick_batch_length();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 70)
			return $urandom_range(6, 1);
		if (r < 95)
			return $urandom_range(30, 7);
		return $urandom_range(120, 31);
	endfunction

	function automatic stimulus_row_t row_write(
		input logic [CFG_IDX_W-1:0] idx,
		input logic [DATA_W-1:0]    value
	);
		stimulus_row_t row;
		row.kind = ROW_WRITE;
		row.reg_index = idx;
		row.value = value;
		row.meas = '0;
		row.obs = '0;
		row.last = 1'b0;
		row.typed = 1'b0;
		row.want = '{default: '0};
		return row;
	endfunction

	function automatic stimulus_row_t row_sample(
		input logic signed [DATA_W-1:0] m,
		input logic signed [DATA_W-1:0] o,
		input logic                     l,
		input logic                     typed,
		input logic signed [DATA_W-1:0] pred,
		input logic [DATA_W-1:0]        mean,
		input logic                     valid
	);
		stimulus_row_t row;
		row.kind = ROW_SAMPLE;
		row.reg_index = REG_COEF_0;
		row.value = '0;
		row.meas = m;
		row.obs = o;
		row.last = l;
		row.typed = typed;
		row.want.prediction = pred;
		row.want.mean_error = mean;
		row.want.error_valid = valid;
		return row;
	endfunction

	// single register write, enable high for one cycle
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic write_coefficients(
		input logic [DATA_W-1:0] c0,
		input logic [DATA_W-1:0] c1,
		input logic [DATA_W-1:0] c2,
		input logic [DATA_W-1:0] c3
	);
		write_reg(REG_COEF_0, c0);
		write_reg(REG_COEF_1, c1);
		write_reg(REG_COEF_2, c2);
		write_reg(REG_COEF_3, c3);
	endtask

	// stop offering and wait until every result word has come back
	task automatic settle_block();
		@(negedge clk);
		push <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// offer one sample word after a gap and wait for the block to take it
	task automatic send_sample(
		input logic signed [DATA_W-1:0] m,
		input logic signed [DATA_W-1:0] o,
		input logic                     l,
		input int unsigned              gap,
		input logic                     typed,
		input result_word_t             want
	);
		repeat (gap) begin
			@(negedge clk);
			push <= 1'b0;
		end
		@(negedge clk);
		push <= 1'b1;
		measurement <= m;
		observation <= o;
		last_sample <= l;
		typed_expect <= typed;
		typed_word <= want;
		do
			@(posedge clk);
		while (full);
	endtask

	// result side: random stalls, one long hold-off on request
	initial begin : result_sink
		int unsigned pause;
		pop = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_request = 1'b0;
			end else if (fast_mode || $urandom_range(99) < 60) begin
				pop <= 1'b1;
			end else begin
				pause = 1 + pick_gap();
				pop <= 1'b0;
				repeat (pause - 1) @(negedge clk);
			end
		end
	end

	// stimulus and end of run
	initial begin
		stimulus_row_t directed_rows [$];
		result_word_t  none;
		int unsigned   ph;
		int unsigned   n;
		int unsigned   left_in_batch;
		logic          closing;

		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = REG_COEF_0;
		cfg_data = '0;
		push = 1'b0;
		measurement = '0;
		observation = '0;
		last_sample = 1'b0;
		typed_expect = 1'b0;
		typed_word = '{default: '0};
		none = '{default: '0};
		fast_mode = 1'b0;
		hold_request = 1'b0;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// zero coefficients after reset: prediction is always zero
		directed_rows.push_back(row_sample('0, '0, 1'b1, 1'b1, '0, '0, 1'b1));
		directed_rows.push_back(row_sample(Q_MAX, Q_MAX, 1'b0, 1'b1, '0, '0, 1'b0));
		directed_rows.push_back(row_sample(Q_MIN, Q_MIN, 1'b1, 1'b0, '0, '0, 1'b0));
		// one-sample batch whose mean overflows the output
		directed_rows.push_back(row_sample('0, Q_MIN, 1'b1, 1'b1, '0, 32'hFFFFFFFF, 1'b1));
		// 1 + x + x^2 + x^3
		directed_rows.push_back(row_write(REG_COEF_0, Q_ONE_FX));
		directed_rows.push_back(row_write(REG_COEF_1, Q_ONE_FX));
		directed_rows.push_back(row_write(REG_COEF_2, Q_ONE_FX));
		directed_rows.push_back(row_write(REG_COEF_3, Q_ONE_FX));
		directed_rows.push_back(row_sample(Q_ONE_FX, 32'sh00040000, 1'b1, 1'b1,
			32'sh00040000, '0, 1'b1));
		directed_rows.push_back(row_sample(32'sh00020000, '0, 1'b0, 1'b1,
			32'sh000F0000, '0, 1'b0));
		// powers saturating both ways
		directed_rows.push_back(row_sample(Q_MAX, Q_MIN, 1'b0, 1'b0, '0, '0, 1'b0));
		directed_rows.push_back(row_sample(Q_MIN, Q_MAX, 1'b1, 1'b0, '0, '0, 1'b0));
		// smallest negative step, floor rounding of the powers
		directed_rows.push_back(row_sample(32'shFFFFFFFF, 32'sh00000001, 1'b1, 1'b0,
			'0, '0, 1'b0));
		directed_rows.push_back(row_sample(Q_MINUS_ONE, '0, 1'b1, 1'b1, '0, '0, 1'b1));
		// extreme weights, terms cancelling and saturating
		directed_rows.push_back(row_write(REG_COEF_0, Q_MIN));
		directed_rows.push_back(row_write(REG_COEF_1, Q_MAX));
		directed_rows.push_back(row_write(REG_COEF_2, Q_MIN));
		directed_rows.push_back(row_write(REG_COEF_3, Q_MAX));
		directed_rows.push_back(row_sample(Q_ONE_FX, '0, 1'b0, 1'b0, '0, '0, 1'b0));
		directed_rows.push_back(row_sample(Q_MINUS_ONE, Q_MAX, 1'b0, 1'b0, '0, '0, 1'b0));
		directed_rows.push_back(row_sample(32'sh7FFF0000, Q_MIN, 1'b1, 1'b0, '0, '0, 1'b0));
		// negative weight of one lsb on the constant only
		directed_rows.push_back(row_write(REG_COEF_0, 32'hFFFFFFFF));
		directed_rows.push_back(row_write(REG_COEF_1, '0));
		directed_rows.push_back(row_write(REG_COEF_2, '0));
		directed_rows.push_back(row_write(REG_COEF_3, '0));
		directed_rows.push_back(row_sample(Q_MIN, Q_MIN, 1'b1, 1'b0, '0, '0, 1'b0));

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_WRITE) begin
				settle_block();
				write_reg(directed_rows[i].reg_index, directed_rows[i].value);
			end else begin
				send_sample(directed_rows[i].meas, directed_rows[i].obs, directed_rows[i].last,
					pick_gap(), directed_rows[i].typed, directed_rows[i].want);
			end
		end

		// random batches under several weight settings
		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			settle_block();
			write_coefficients(pick_coefficient(coef_style_t'(ph % 4)),
				pick_coefficient(coef_style_t'(ph % 4)),
				pick_coefficient(coef_style_t'(ph % 4)),
				pick_coefficient(coef_style_t'(ph % 4)));
			left_in_batch = 0;
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (left_in_batch == 0)
					left_in_batch = pick_batch_length();
				fast_mode = (n % 100) < 20;
				if (ph == 2 && n == 50)
					hold_request = 1'b1;
				closing = (left_in_batch == 1) || (n == PHASE_ITEMS - 1);
				send_sample(random_fixed(), random_fixed(), closing,
					fast_mode ? 0 : pick_gap(), 1'b0, none);
				left_in_batch = closing ? 0 : left_in_batch - 1;
			end
			fast_mode = 1'b0;
		end

		// drain and report
		@(negedge clk);
		push <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("%0d samples in %0d batches (longest %0d), %0d coefficient writes",
			samples_taken, batches_closed, longest_batch, writes_seen);
		$display("%0d result words compared, input stalled %0d cycles, %0d mismatches",
			words_checked, input_stalls, mismatches);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
